/* sv/best_fit_heap_allocator_macros.svh */
// ---------------------------------------------------------------------------
// Best-fit heap allocator assertion macros
// Shared concurrent check forms on i_clk, quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BFHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bfha_pkg.sv */
// ---------------------------------------------------------------------------
// Best-fit heap allocator package
// Sizes, codes and the extent cell command shared by the allocator modules.
// ---------------------------------------------------------------------------
package bfha_pkg;

    localparam int MAX_FREE  = 64;
    localparam int MAX_USED  = 256;
    localparam int ADDR_BITS = 24;

    localparam int SIZE_W   = 24;
    localparam int SPAN_W   = 25;
    localparam int HDR_W    = 8;
    localparam int CFG_W    = 25;
    localparam int STATUS_W = 3;

    localparam int LIM_EXP = (ADDR_BITS < 24) ? ADDR_BITS : 24;
    localparam logic [SPAN_W-1:0] LIM_CAP      = SPAN_W'(1) << LIM_EXP;
    localparam logic [SPAN_W-1:0] LIMIT_RESET  = SPAN_W'(1) << 24;
    localparam logic [HDR_W-1:0]  HEADER_RESET = HDR_W'(32);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic CFG_IDX_LIMIT  = 1'b0;
    localparam logic CFG_IDX_HEADER = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef struct packed {
        logic [SIZE_W-1:0] start;
        logic [SPAN_W-1:0] span;
    } t_extent;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_WRITE,
        CELL_REMOVE,
        CELL_MERGE,
        CELL_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_extent  data;
    } t_cell_cmd;

endpackage

/* sv/bfha_cell.sv */
// ---------------------------------------------------------------------------
// Extent cell
// One (start, span) slot of a chain; takes its neighbor, the head or new data.
// ---------------------------------------------------------------------------
module bfha_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  bfha_pkg::t_cell_cmd i_cmd,
    input  logic [IW-1:0]       i_idx,
    input  logic [IW-1:0]       i_tail,
    input  bfha_pkg::t_extent   i_head,
    input  bfha_pkg::t_extent   i_next,
    input  bfha_pkg::t_extent   i_prev,
    output bfha_pkg::t_extent   o_ext
);

    localparam logic [IW-1:0] MY = IW'(IDX);

    bfha_pkg::t_extent r_ext;
    bfha_pkg::t_extent n_ext;

    always_comb begin
        n_ext = r_ext;
        unique case (i_cmd.op)
            bfha_pkg::CELL_ROTATE: begin
                if (MY == i_tail) begin
                    n_ext = i_head;
                end else if (MY < i_tail) begin
                    n_ext = i_next;
                end
            end
            bfha_pkg::CELL_WRITE: begin
                if (MY == i_idx) begin
                    n_ext = i_cmd.data;
                end
            end
            bfha_pkg::CELL_REMOVE: begin
                if (MY >= i_idx) begin
                    n_ext = i_next;
                end
            end
            bfha_pkg::CELL_MERGE: begin
                if (MY == i_idx) begin
                    n_ext = i_cmd.data;
                end else if (MY > i_idx) begin
                    n_ext = i_next;
                end
            end
            bfha_pkg::CELL_INSERT: begin
                if (MY == i_idx) begin
                    n_ext = i_cmd.data;
                end else if (MY > i_idx) begin
                    n_ext = i_prev;
                end
            end
            default: begin
                n_ext = r_ext;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ext <= n_ext;
    end

    assign o_ext = r_ext;

endmodule

/* sv/bfha_chain.sv */
// ---------------------------------------------------------------------------
// Extent chain
// A row of extent cells; the head cell is the one the controller inspects.
// ---------------------------------------------------------------------------
module bfha_chain #(
    parameter int DEPTH = 64,
    localparam int IW   = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  bfha_pkg::t_cell_cmd i_cmd,
    input  logic [IW-1:0]       i_idx,
    input  logic [IW-1:0]       i_tail,
    output bfha_pkg::t_extent   o_head
);

    bfha_pkg::t_extent w_ext [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bfha_pkg::t_extent w_next;
        bfha_pkg::t_extent w_prev;

        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_ext[g];
        end else begin : g_mid
            assign w_next = w_ext[g+1];
        end

        if (g == 0) begin : g_first
            assign w_prev = w_ext[g];
        end else begin : g_rest
            assign w_prev = w_ext[g-1];
        end

        bfha_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (i_cmd),
            .i_idx  (i_idx),
            .i_tail (i_tail),
            .i_head (w_ext[0]),
            .i_next (w_next),
            .i_prev (w_prev),
            .o_ext  (w_ext[g])
        );
    end

    assign o_head = w_ext[0];

endmodule

/* sv/best_fit_heap_allocator.sv */
// ---------------------------------------------------------------------------
// Best-fit heap allocator
// Address-ordered free extent chain and used block chain, walked by rotation.
//
//  channel   ports                                          direction
//  request   start, busy, i_func, i_request_size,           in
//            i_user_address
//  result    o_valid, o_result_address, o_status            out
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata               in
//
// Allocate: accept in S_IDLE, walk of every free extent in S_FSCAN, update in
// S_AUPD. Free: walk of the used blocks up to the match in S_UFIND, walk of every
// free extent in S_FINS, update in S_FAPPLY. Null, zero and full used table
// cases and a free with no used blocks answer in the accept cycle; a full free
// table ends the used walk. Each chain's rotating head is walked one entry per cycle.
// Result strobe is registered from the final state and lasts one cycle; no stall.
// Synchronous active-low reset empties both chains and clears the heap top.
// ---------------------------------------------------------------------------
`include "best_fit_heap_allocator_macros.svh"

module best_fit_heap_allocator #(
    parameter int MAX_FREE = bfha_pkg::MAX_FREE,
    parameter int MAX_USED = bfha_pkg::MAX_USED
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_user_address,
    output logic                          o_valid,
    output logic [bfha_pkg::SIZE_W-1:0]   o_result_address,
    output logic [bfha_pkg::STATUS_W-1:0] o_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bfha_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int FIW = $clog2(MAX_FREE);
    localparam int FCW = $clog2(MAX_FREE + 1);
    localparam int UIW = $clog2(MAX_USED);
    localparam int UCW = $clog2(MAX_USED + 1);
    localparam int SW  = bfha_pkg::SPAN_W;
    localparam int AW  = bfha_pkg::SIZE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FSCAN,
        S_AUPD,
        S_UFIND,
        S_FINS,
        S_FAPPLY
    } t_state;

    t_state                       r_state, n_state;
    logic [FCW-1:0]               r_fcnt, n_fcnt;
    logic [UCW-1:0]               r_ucnt, n_ucnt;
    logic [SW-1:0]                r_heap_top, n_heap_top;
    logic [SW-1:0]                r_limit, n_limit;
    logic [bfha_pkg::HDR_W-1:0]   r_hdr, n_hdr;
    logic                         r_out_valid, n_out_valid;
    logic [AW-1:0]                r_out_addr, n_out_addr;
    bfha_pkg::t_status            r_out_status, n_out_status;

    logic [AW-1:0]                r_size, n_size;
    logic [AW-1:0]                r_addr, n_addr;
    logic [FIW-1:0]               r_fi, n_fi;
    logic [UIW-1:0]               r_ui, n_ui;
    logic                         r_found, n_found;
    logic [FIW-1:0]               r_bidx, n_bidx;
    logic [SW-1:0]                r_bdiff, n_bdiff;
    bfha_pkg::t_extent            r_bext, n_bext;
    bfha_pkg::t_extent            r_blk, n_blk;
    logic                         r_nfound, n_nfound;
    logic [FIW-1:0]               r_pos, n_pos;
    bfha_pkg::t_extent            r_prev, n_prev;
    bfha_pkg::t_extent            r_next, n_next;

    bfha_pkg::t_extent   w_fhead, w_uhead;
    bfha_pkg::t_cell_cmd w_fcmd, w_ucmd;
    logic [FIW-1:0]      w_fidx;
    logic [UIW-1:0]      w_uidx;
    logic [FIW-1:0]      w_ftail;
    logic [UIW-1:0]      w_utail;

    logic [SW-1:0] w_hdr, w_sz, w_cap, w_diff, w_lim, w_need, w_bcap;
    logic          w_fits, w_split, w_umatch, w_flast, w_ulast;
    logic          w_ffull, w_ufull, w_mnext, w_mprev, w_scan;
    logic [FIW-1:0] w_pos;

    assign w_hdr    = SW'(r_hdr);
    assign w_sz     = SW'(r_size);
    assign w_cap    = w_fhead.span - w_hdr;
    assign w_fits   = (w_fhead.span >= w_hdr) && (w_cap >= w_sz);
    assign w_diff   = w_cap - w_sz;
    assign w_lim    = (r_limit < bfha_pkg::LIM_CAP) ? r_limit : bfha_pkg::LIM_CAP;
    assign w_need   = w_hdr + w_sz;
    assign w_bcap   = r_bext.span - w_hdr;
    assign w_split  = w_bcap > w_need;
    assign w_umatch = (SW'(w_uhead.start) + w_hdr) == SW'(r_addr);
    assign w_flast  = FCW'(r_fi) == (r_fcnt - FCW'(1));
    assign w_ulast  = UCW'(r_ui) == (r_ucnt - UCW'(1));
    assign w_ffull  = r_fcnt == FCW'(MAX_FREE);
    assign w_ufull  = r_ucnt == UCW'(MAX_USED);
    assign w_ftail  = FIW'(r_fcnt - FCW'(1));
    assign w_utail  = UIW'(r_ucnt - UCW'(1));
    assign w_pos    = r_nfound ? r_pos : FIW'(r_fcnt);
    assign w_mnext  = r_nfound
                      && ((SW'(r_blk.start) + r_blk.span) == SW'(r_next.start));
    assign w_mprev  = (w_pos != '0)
                      && ((SW'(r_prev.start) + r_prev.span) == SW'(r_blk.start));
    assign w_scan   = (r_state == S_FSCAN) || (r_state == S_FINS);

    always_comb begin
        n_state      = r_state;
        n_fcnt       = r_fcnt;
        n_ucnt       = r_ucnt;
        n_heap_top   = r_heap_top;
        n_limit      = r_limit;
        n_hdr        = r_hdr;
        n_out_valid  = 1'b0;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_size       = r_size;
        n_addr       = r_addr;
        n_fi         = r_fi;
        n_ui         = r_ui;
        n_found      = r_found;
        n_bidx       = r_bidx;
        n_bdiff      = r_bdiff;
        n_bext       = r_bext;
        n_blk        = r_blk;
        n_nfound     = r_nfound;
        n_pos        = r_pos;
        n_prev       = r_prev;
        n_next       = r_next;
        w_fcmd       = '{op: bfha_pkg::CELL_HOLD, data: '0};
        w_ucmd       = '{op: bfha_pkg::CELL_HOLD, data: '0};
        w_fidx       = '0;
        w_uidx       = '0;

        if (i_cfg_we) begin
            if (i_cfg_idx == bfha_pkg::CFG_IDX_LIMIT) begin
                n_limit = i_cfg_wdata;
            end else begin
                n_hdr = i_cfg_wdata[bfha_pkg::HDR_W-1:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_size   = i_request_size;
                    n_addr   = i_user_address;
                    n_fi     = '0;
                    n_ui     = '0;
                    n_found  = 1'b0;
                    n_nfound = 1'b0;
                    n_out_addr = '0;
                    if (i_func == bfha_pkg::FUNC_ALLOC) begin
                        if (i_request_size == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = bfha_pkg::ST_NULL;
                        end else if (w_ufull) begin
                            n_out_valid  = 1'b1;
                            n_out_status = bfha_pkg::ST_FULL;
                        end else begin
                            n_state = (r_fcnt == '0) ? S_AUPD : S_FSCAN;
                        end
                    end else begin
                        if (i_user_address == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = bfha_pkg::ST_NULL;
                        end else if (r_ucnt == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = bfha_pkg::ST_UNKNOWN;
                        end else begin
                            n_state = S_UFIND;
                        end
                    end
                end
            end
            S_FSCAN: begin
                w_fcmd.op = bfha_pkg::CELL_ROTATE;
                if (w_fits && (!r_found || (w_diff < r_bdiff))) begin
                    n_found = 1'b1;
                    n_bidx  = r_fi;
                    n_bdiff = w_diff;
                    n_bext  = w_fhead;
                end
                n_fi = r_fi + FIW'(1);
                if (w_flast) begin
                    n_state = S_AUPD;
                end
            end
            S_AUPD: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                if (r_found) begin
                    w_fidx = r_bidx;
                    if (w_split) begin
                        w_fcmd.op         = bfha_pkg::CELL_WRITE;
                        w_fcmd.data.start = r_bext.start + w_need[AW-1:0];
                        w_fcmd.data.span  = r_bext.span - w_need;
                        w_ucmd.data.span  = w_need;
                    end else begin
                        w_fcmd.op        = bfha_pkg::CELL_REMOVE;
                        n_fcnt           = r_fcnt - FCW'(1);
                        w_ucmd.data.span = r_bext.span;
                    end
                    w_ucmd.op         = bfha_pkg::CELL_INSERT;
                    w_ucmd.data.start = r_bext.start;
                    n_ucnt            = r_ucnt + UCW'(1);
                    n_out_status      = bfha_pkg::ST_OK;
                    n_out_addr        = r_bext.start + AW'(r_hdr);
                end else if ((r_heap_top > w_lim) || (w_need > (w_lim - r_heap_top))) begin
                    n_out_status = bfha_pkg::ST_EXHAUSTED;
                    n_out_addr   = '0;
                end else begin
                    w_ucmd.op         = bfha_pkg::CELL_INSERT;
                    w_ucmd.data.start = r_heap_top[AW-1:0];
                    w_ucmd.data.span  = w_need;
                    n_ucnt            = r_ucnt + UCW'(1);
                    n_heap_top        = r_heap_top + w_need;
                    n_out_status      = bfha_pkg::ST_OK;
                    n_out_addr        = r_heap_top[AW-1:0] + AW'(r_hdr);
                end
            end
            S_UFIND: begin
                if (w_umatch) begin
                    if (w_ffull) begin
                        n_state      = S_IDLE;
                        n_out_valid  = 1'b1;
                        n_out_status = bfha_pkg::ST_FULL;
                    end else begin
                        w_ucmd.op = bfha_pkg::CELL_REMOVE;
                        n_ucnt    = r_ucnt - UCW'(1);
                        n_blk     = w_uhead;
                        n_state   = (r_fcnt == '0) ? S_FAPPLY : S_FINS;
                    end
                end else begin
                    w_ucmd.op = bfha_pkg::CELL_ROTATE;
                    n_ui      = r_ui + UIW'(1);
                    if (w_ulast) begin
                        n_state      = S_IDLE;
                        n_out_valid  = 1'b1;
                        n_out_status = bfha_pkg::ST_UNKNOWN;
                    end
                end
            end
            S_FINS: begin
                w_fcmd.op = bfha_pkg::CELL_ROTATE;
                if (!r_nfound) begin
                    if (w_fhead.start > r_blk.start) begin
                        n_nfound = 1'b1;
                        n_pos    = r_fi;
                        n_next   = w_fhead;
                    end else begin
                        n_prev = w_fhead;
                    end
                end
                n_fi = r_fi + FIW'(1);
                if (w_flast) begin
                    n_state = S_FAPPLY;
                end
            end
            S_FAPPLY: begin
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_out_status = bfha_pkg::ST_OK;
                priority if (w_mprev && w_mnext) begin
                    w_fcmd.op         = bfha_pkg::CELL_MERGE;
                    w_fidx            = w_pos - FIW'(1);
                    w_fcmd.data.start = r_prev.start;
                    w_fcmd.data.span  = r_prev.span + r_blk.span + r_next.span;
                    n_fcnt            = r_fcnt - FCW'(1);
                end else if (w_mprev) begin
                    w_fcmd.op         = bfha_pkg::CELL_WRITE;
                    w_fidx            = w_pos - FIW'(1);
                    w_fcmd.data.start = r_prev.start;
                    w_fcmd.data.span  = r_prev.span + r_blk.span;
                end else if (w_mnext) begin
                    w_fcmd.op         = bfha_pkg::CELL_WRITE;
                    w_fidx            = w_pos;
                    w_fcmd.data.start = r_blk.start;
                    w_fcmd.data.span  = r_blk.span + r_next.span;
                end else begin
                    w_fcmd.op   = bfha_pkg::CELL_INSERT;
                    w_fidx      = w_pos;
                    w_fcmd.data = r_blk;
                    n_fcnt      = r_fcnt + FCW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fcnt       <= '0;
            r_ucnt       <= '0;
            r_heap_top   <= '0;
            r_limit      <= bfha_pkg::LIMIT_RESET;
            r_hdr        <= bfha_pkg::HEADER_RESET;
            r_out_valid  <= 1'b0;
            r_out_addr   <= '0;
            r_out_status <= bfha_pkg::ST_OK;
        end else begin
            r_state      <= n_state;
            r_fcnt       <= n_fcnt;
            r_ucnt       <= n_ucnt;
            r_heap_top   <= n_heap_top;
            r_limit      <= n_limit;
            r_hdr        <= n_hdr;
            r_out_valid  <= n_out_valid;
            r_out_addr   <= n_out_addr;
            r_out_status <= n_out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size   <= n_size;
        r_addr   <= n_addr;
        r_fi     <= n_fi;
        r_ui     <= n_ui;
        r_found  <= n_found;
        r_bidx   <= n_bidx;
        r_bdiff  <= n_bdiff;
        r_bext   <= n_bext;
        r_blk    <= n_blk;
        r_nfound <= n_nfound;
        r_pos    <= n_pos;
        r_prev   <= n_prev;
        r_next   <= n_next;
    end

    bfha_chain #(
        .DEPTH (MAX_FREE)
    ) u_free_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_fcmd),
        .i_idx  (w_fidx),
        .i_tail (w_ftail),
        .o_head (w_fhead)
    );

    bfha_chain #(
        .DEPTH (MAX_USED)
    ) u_used_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_ucmd),
        .i_idx  (w_uidx),
        .i_tail (w_utail),
        .o_head (w_uhead)
    );

    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

    `BFHA_ASSERT_NOW(a_free_cnt_max, 1'b1, r_fcnt <= FCW'(MAX_FREE), "free count overflow")
    `BFHA_ASSERT_NOW(a_used_cnt_max, 1'b1, r_ucnt <= UCW'(MAX_USED), "used count overflow")
    `BFHA_ASSERT_NEXT(a_top_grows, 1'b1, r_heap_top >= $past(r_heap_top), "heap top shrank")
    `BFHA_ASSERT_NOW(a_scan_range, w_scan, FCW'(r_fi) < r_fcnt, "scan index past count")
    `BFHA_ASSERT_NOW(a_strobe_cause, o_valid, $past(busy) || $past(start), "stray result")

endmodule

/* dv/best_fit_heap_allocator_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Best-fit heap allocator testbench
// Drives allocate and free commands with random gaps and changes the limit
// and header registers between phases. A scoreboard predicts every granted
// address and status from its own copy of the free table, used table and
// heap top, and checks each result strobe in order.
// ---------------------------------------------------------------------------
module best_fit_heap_allocator_tb;

    typedef struct {
        logic [bfha_pkg::SIZE_W-1:0] addr;
        bfha_pkg::t_status           st;
    } t_grant;

    class heap_scoreboard;
        longint fx_start[$];
        longint fx_span[$];
        bit     ux_valid[bfha_pkg::MAX_USED];
        longint ux_start[bfha_pkg::MAX_USED];
        longint ux_span[bfha_pkg::MAX_USED];
        longint heap_top;
        longint heap_limit;
        longint header;
        t_grant grants_due[$];
        int     errors;

        function void reset_state();
            fx_start.delete();
            fx_span.delete();
            foreach (ux_valid[i]) ux_valid[i] = 0;
            heap_top   = 0;
            heap_limit = bfha_pkg::LIMIT_RESET;
            header     = bfha_pkg::HEADER_RESET;
            errors     = 0;
        endfunction

        function void write_reg(logic idx, logic [bfha_pkg::CFG_W-1:0] data);
            if (idx == bfha_pkg::CFG_IDX_LIMIT) heap_limit = data;
            else header = data[bfha_pkg::HDR_W-1:0];
        endfunction

        function longint region_cap();
            longint lim;
            lim = heap_limit;
            if (lim > longint'(bfha_pkg::LIM_CAP)) lim = longint'(bfha_pkg::LIM_CAP);
            return lim;
        endfunction

        function bfha_pkg::t_status allocate(longint size, output longint addr);
            int slot, best;
            bit found;
            longint best_diff, cap, d, base, span;
            slot = -1;
            best = 0;
            found = 0;
            best_diff = 0;
            addr = 0;
            if (size == 0) return bfha_pkg::ST_NULL;
            for (int i = 0; i < bfha_pkg::MAX_USED; i++)
                if (!ux_valid[i]) begin
                    slot = i;
                    break;
                end
            if (slot < 0) return bfha_pkg::ST_FULL;
            for (int i = 0; i < fx_start.size(); i++) begin
                if (fx_span[i] < header) continue;
                cap = fx_span[i] - header;
                if (cap < size) continue;
                d = cap - size;
                if (!found || d < best_diff) begin
                    best = i;
                    best_diff = d;
                    found = 1;
                end
                if (d == 0) break;
            end
            if (found) begin
                base = fx_start[best];
                if (fx_span[best] - header > header + size) begin
                    span = header + size;
                    fx_start[best] = base + span;
                    fx_span[best] -= span;
                end else begin
                    span = fx_span[best];
                    fx_start.delete(best);
                    fx_span.delete(best);
                end
            end else begin
                span = header + size;
                if (heap_top > region_cap() || span > region_cap() - heap_top)
                    return bfha_pkg::ST_EXHAUSTED;
                base = heap_top;
                heap_top += span;
            end
            ux_valid[slot] = 1;
            ux_start[slot] = base;
            ux_span[slot]  = span;
            addr = (base + header) & 24'hFFFFFF;
            return bfha_pkg::ST_OK;
        endfunction

        function bfha_pkg::t_status release_block(longint addr);
            int slot, pos;
            longint base, span;
            slot = -1;
            if (addr == 0) return bfha_pkg::ST_NULL;
            for (int i = 0; i < bfha_pkg::MAX_USED; i++)
                if (ux_valid[i] && ux_start[i] + header == addr) begin
                    slot = i;
                    break;
                end
            if (slot < 0) return bfha_pkg::ST_UNKNOWN;
            if (fx_start.size() >= bfha_pkg::MAX_FREE) return bfha_pkg::ST_FULL;
            base = ux_start[slot];
            span = ux_span[slot];
            ux_valid[slot] = 0;
            pos = fx_start.size();
            for (int i = 0; i < fx_start.size(); i++)
                if (fx_start[i] > base) begin
                    pos = i;
                    break;
                end
            fx_start.insert(pos, base);
            fx_span.insert(pos, span);
            if (pos + 1 < fx_start.size() && fx_start[pos] + fx_span[pos] == fx_start[pos+1])
            begin
                fx_span[pos] += fx_span[pos+1];
                fx_start.delete(pos + 1);
                fx_span.delete(pos + 1);
            end
            if (pos > 0 && fx_start[pos-1] + fx_span[pos-1] == fx_start[pos]) begin
                fx_span[pos-1] += fx_span[pos];
                fx_start.delete(pos);
                fx_span.delete(pos);
            end
            return bfha_pkg::ST_OK;
        endfunction

        function void note_transfer(logic func, logic [bfha_pkg::SIZE_W-1:0] size,
                                    logic [bfha_pkg::SIZE_W-1:0] uaddr);
            t_grant g;
            longint a;
            a = 0;
            if (func == bfha_pkg::FUNC_ALLOC) g.st = allocate(size, a);
            else g.st = release_block(uaddr);
            g.addr = (g.st == bfha_pkg::ST_OK) ? a[bfha_pkg::SIZE_W-1:0] : '0;
            grants_due.push_back(g);
        endfunction

        function void check_result(logic [bfha_pkg::SIZE_W-1:0] addr,
                                   logic [bfha_pkg::STATUS_W-1:0] st);
            t_grant g;
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual addr %h status %0d",
                         $time, addr, st);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            if (addr !== g.addr) begin
                $display("%0t: result_address mismatch: expected %h, actual %h",
                         $time, g.addr, addr);
                errors++;
            end
            if (st !== g.st) begin
                $display("%0t: status mismatch: expected %0d, actual %0d", $time, g.st, st);
                errors++;
            end
        endfunction

        function logic [bfha_pkg::SIZE_W-1:0] slot_addr(int i);
            if (!ux_valid[i]) return '0;
            return bfha_pkg::SIZE_W'(ux_start[i] + header);
        endfunction

        function logic [bfha_pkg::SIZE_W-1:0] pick_live();
            int k;
            k = $urandom_range(0, bfha_pkg::MAX_USED - 1);
            for (int n = 0; n < bfha_pkg::MAX_USED; n++)
                if (ux_valid[(k + n) % bfha_pkg::MAX_USED])
                    return slot_addr((k + n) % bfha_pkg::MAX_USED);
            return '0;
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_func;
    logic [bfha_pkg::SIZE_W-1:0]   i_request_size;
    logic [bfha_pkg::SIZE_W-1:0]   i_user_address;
    logic                          o_valid;
    logic [bfha_pkg::SIZE_W-1:0]   o_result_address;
    logic [bfha_pkg::STATUS_W-1:0] o_status;
    logic                          i_cfg_we;
    logic                          i_cfg_idx;
    logic [bfha_pkg::CFG_W-1:0]    i_cfg_wdata;

    heap_scoreboard sb;

    best_fit_heap_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_request_size   (i_request_size),
        .i_user_address   (i_user_address),
        .o_valid          (o_valid),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("best_fit_heap_allocator_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        logic [bfha_pkg::SIZE_W-1:0]   a;
        logic [bfha_pkg::STATUS_W-1:0] s;
        if (i_rst_n && o_valid) begin
            a = o_result_address;
            s = o_status;
            #1 sb.check_result(a, s);
        end
    end

    task automatic send(logic func, logic [bfha_pkg::SIZE_W-1:0] size,
                        logic [bfha_pkg::SIZE_W-1:0] uaddr);
        int r, gap;
        start          <= 1'b1;
        i_func         <= func;
        i_request_size <= size;
        i_user_address <= uaddr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_transfer(func, size, uaddr);
        r = $urandom_range(0, 99);
        gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic alloc(logic [bfha_pkg::SIZE_W-1:0] size);
        send(bfha_pkg::FUNC_ALLOC, size, bfha_pkg::SIZE_W'($urandom));
    endtask

    task automatic free_addr(logic [bfha_pkg::SIZE_W-1:0] uaddr);
        send(bfha_pkg::FUNC_FREE, bfha_pkg::SIZE_W'($urandom), uaddr);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.grants_due.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [bfha_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_ops(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 30)      alloc(bfha_pkg::SIZE_W'($urandom_range(1, 256)));
            else if (r < 42) alloc(bfha_pkg::SIZE_W'($urandom_range(1, 4096)));
            else if (r < 45) alloc(bfha_pkg::SIZE_W'($urandom));
            else if (r < 48) alloc('0);
            else if (r < 88) free_addr(sb.pick_live());
            else if (r < 95) free_addr(bfha_pkg::SIZE_W'($urandom));
            else             free_addr('0);
        end
    endtask

    initial begin
        logic [bfha_pkg::SIZE_W-1:0] a;
        sb = new();
        sb.reset_state();
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = bfha_pkg::FUNC_ALLOC;
        i_request_size = '0;
        i_user_address = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = bfha_pkg::CFG_IDX_LIMIT;
        i_cfg_wdata    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero header: first block at address zero, then a tight limit
        write_reg(bfha_pkg::CFG_IDX_HEADER, '0);
        write_reg(bfha_pkg::CFG_IDX_LIMIT, bfha_pkg::CFG_W'(4096));
        alloc(bfha_pkg::SIZE_W'(10));
        free_addr('0);
        alloc(bfha_pkg::SIZE_W'(5000));
        alloc(bfha_pkg::SIZE_W'(4000));
        alloc(bfha_pkg::SIZE_W'(200));
        drain();

        write_reg(bfha_pkg::CFG_IDX_HEADER, {17'h1FFFF, 8'd32});
        write_reg(bfha_pkg::CFG_IDX_LIMIT, bfha_pkg::LIMIT_RESET);
        alloc('0);
        free_addr('0);
        alloc(bfha_pkg::SIZE_W'(1));
        alloc(bfha_pkg::SIZE_W'(100));
        alloc(bfha_pkg::SIZE_W'(300));
        alloc(bfha_pkg::SIZE_W'(64));
        alloc(24'hFFFFFF);
        drain();
        a = sb.slot_addr(2);
        free_addr(a);
        free_addr(a);
        free_addr(24'h5A5A5A);
        alloc(bfha_pkg::SIZE_W'(300));
        free_addr(sb.slot_addr(3));
        free_addr(sb.slot_addr(2));
        alloc(bfha_pkg::SIZE_W'(20));
        alloc(bfha_pkg::SIZE_W'(64));
        free_addr(sb.slot_addr(1));
        drain();

        // header change: outstanding blocks are then freed at start plus the new header
        write_reg(bfha_pkg::CFG_IDX_HEADER, bfha_pkg::CFG_W'(255));
        free_addr(sb.pick_live());
        random_ops(200);
        drain();

        write_reg(bfha_pkg::CFG_IDX_LIMIT, '0);
        random_ops(30);
        drain();

        // fill the used table, then scatter frees until the free table is full
        write_reg(bfha_pkg::CFG_IDX_HEADER, bfha_pkg::CFG_W'(8));
        write_reg(bfha_pkg::CFG_IDX_LIMIT, bfha_pkg::LIMIT_RESET);
        repeat (bfha_pkg::MAX_USED + 4) alloc(bfha_pkg::SIZE_W'($urandom_range(1, 16)));
        drain();
        for (int i = 0; i < bfha_pkg::MAX_USED; i += 2) free_addr(sb.slot_addr(i));
        alloc(bfha_pkg::SIZE_W'(3));
        drain();
        for (int i = 1; i < bfha_pkg::MAX_USED; i += 2) free_addr(sb.slot_addr(i));
        drain();

        write_reg(bfha_pkg::CFG_IDX_HEADER, bfha_pkg::CFG_W'(32));
        write_reg(bfha_pkg::CFG_IDX_LIMIT, bfha_pkg::CFG_W'(200000));
        random_ops(80);
        drain();

        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.grants_due.size() == 0)
            $display("best_fit_heap_allocator_tb OK");
        else
            $display("best_fit_heap_allocator_tb NOT OK");
        $finish;
    end
endmodule
